@@ hdl/bvot_pkg.sv @@
// bounding volume overlap test: shared types, widths, codes and helpers
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package bvot_pkg;

  localparam int CW      = 32;
  localparam int DW      = CW + 1;
  localparam int SW      = 2 * DW;
  localparam int TW      = SW + 2;
  localparam int XW      = CW + 3;
  localparam int NCOORD  = 6;
  localparam int IDXW    = 3;
  localparam int OPW     = 2;
  localparam int IN_BITS = OPW + NCOORD * CW;
  localparam int IN_TDW  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDW = 8;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] dif_t;
  typedef logic signed [XW-1:0] ext_t;
  typedef logic [DW-1:0]        mag_t;
  typedef logic [SW-1:0]        sq_t;
  typedef logic [TW-1:0]        sum_t;

  typedef enum logic [OPW-1:0] {
    OP_INTERSECT  = 2'd0,
    OP_HAS_POINT  = 2'd1,
    OP_HAS_REGION = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  typedef enum logic {
    KIND_BOX    = 1'b0,
    KIND_SPHERE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    MODE_FLAG = 2'd0,
    MODE_LE   = 2'd1,
    MODE_LT   = 2'd2,
    MODE_LT2  = 2'd3
  } mode_t;

  localparam logic [IDXW-1:0] REG_A_KIND   = 3'd0;
  localparam logic [IDXW-1:0] REG_A_COORD0 = 3'd1;

  typedef struct packed {
    kind_t                     kind;
    logic [NCOORD-1:0][CW-1:0] coord;
  } region_t;

  typedef struct packed {
    op_t     op;
    region_t b;
  } query_t;

  typedef struct packed {
    mode_t           mode;
    logic            flag;
    logic [2:0][DW-1:0] p;
    logic [2:0][DW-1:0] q;
    mag_t            r;
  } prep_t;

  typedef struct packed {
    mode_t           mode;
    logic            flag;
    logic [2:0][SW-1:0] p;
    logic [2:0][SW-1:0] q;
    sq_t             r;
  } sqr_t;

  typedef struct packed {
    logic prep;
    logic square;
    logic sum;
    logic decide;
  } stage_en_t;

  function automatic dif_t ext1(input coord_t x);
    dif_t y;
    y = x;
    return y;
  endfunction

  function automatic ext_t ext3(input coord_t x);
    ext_t y;
    y = x;
    return y;
  endfunction

  function automatic dif_t diff(input coord_t x, input coord_t y);
    return ext1(x) - ext1(y);
  endfunction

  function automatic mag_t mag_of(input dif_t d);
    dif_t n;
    n = -d;
    return d[DW-1] ? mag_t'(n) : mag_t'(d);
  endfunction

endpackage

@@ hdl/bvot_prep.sv @@
// bounding volume overlap test: prep stage, differences, clamps and bound checks
// depends on bvot_pkg
`timescale 1ns / 1ps

module bvot_prep import bvot_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  region_t a,
  input  query_t  qin,
  output prep_t   prep
);

  prep_t prep_next;

  always_comb begin
    coord_t av [NCOORD];
    coord_t bv [NCOORD];
    coord_t sc [3];
    coord_t slo [3];
    coord_t shi [3];
    coord_t t;
    coord_t br;
    ext_t   ce;
    ext_t   ee;
    ext_t   ca;
    mag_t   pd [3];
    mag_t   pc [3];
    mag_t   qd [3];
    mag_t   hi;
    mag_t   rsum;
    mag_t   rdiff;
    mag_t   ra;
    mag_t   rb;
    mag_t   brz;
    logic   bb_ok;
    logic   in_b0;
    logic   in_b3;
    logic   cs_ok;
    for (int i = 0; i < NCOORD; i++) begin
      av[i] = a.coord[i];
      bv[i] = qin.b.coord[i];
    end
    bb_ok = 1'b1;
    in_b0 = 1'b1;
    in_b3 = 1'b1;
    cs_ok = 1'b1;
    br    = bv[3];
    brz   = mag_t'($unsigned(br));
    for (int i = 0; i < 3; i++) begin
      ce = (ext3(av[i]) + ext3(av[i+3])) - (ext3(bv[i]) + ext3(bv[i+3]));
      ee = (ext3(av[i+3]) - ext3(av[i])) + (ext3(bv[i+3]) - ext3(bv[i]));
      ca = ce[XW-1] ? -ce : ce;
      if (ca > ee) begin
        bb_ok = 1'b0;
      end
      if (!(bv[i] >= av[i] && bv[i] <= av[i+3])) begin
        in_b0 = 1'b0;
      end
      if (!(bv[i+3] >= av[i] && bv[i+3] <= av[i+3])) begin
        in_b3 = 1'b0;
      end
      // sphere center clamped into the box, whichever side is the sphere
      if (a.kind == KIND_SPHERE) begin
        sc[i]  = av[i];
        slo[i] = bv[i];
        shi[i] = bv[i+3];
      end else begin
        sc[i]  = bv[i];
        slo[i] = av[i];
        shi[i] = av[i+3];
      end
      t = (sc[i] < shi[i]) ? sc[i] : shi[i];
      if (t < slo[i]) begin
        t = slo[i];
      end
      pc[i] = mag_of(diff(t, sc[i]));
      pd[i] = mag_of(diff(av[i], bv[i]));
      qd[i] = mag_of(diff(av[i], bv[i+3]));
      hi    = mag_of(diff(av[i+3], bv[i]));
      if (!br[CW-1] && (pd[i] < brz || hi < brz)) begin
        cs_ok = 1'b0;
      end
    end
    rsum  = mag_of(ext1(av[3]) + ext1(bv[3]));
    rdiff = mag_of(diff(av[3], bv[3]));
    ra    = mag_of(ext1(av[3]));
    rb    = mag_of(ext1(bv[3]));

    prep_next.mode = MODE_FLAG;
    prep_next.flag = 1'b0;
    prep_next.r    = ra;
    for (int i = 0; i < 3; i++) begin
      prep_next.p[i] = pd[i];
      prep_next.q[i] = qd[i];
    end
    unique case (qin.op)
      OP_INTERSECT: begin
        if (a.kind == KIND_BOX && qin.b.kind == KIND_BOX) begin
          prep_next.flag = bb_ok;
        end else if (a.kind == KIND_SPHERE && qin.b.kind == KIND_SPHERE) begin
          prep_next.mode = MODE_LE;
          prep_next.flag = 1'b1;
          prep_next.r    = rsum;
        end else begin
          prep_next.mode = MODE_LT;
          prep_next.flag = 1'b1;
          prep_next.r    = (a.kind == KIND_SPHERE) ? ra : rb;
          for (int i = 0; i < 3; i++) begin
            prep_next.p[i] = pc[i];
          end
        end
      end
      OP_HAS_POINT: begin
        if (a.kind == KIND_BOX) begin
          prep_next.flag = in_b0;
        end else begin
          prep_next.mode = MODE_LT;
          prep_next.flag = 1'b1;
        end
      end
      OP_HAS_REGION: begin
        if (qin.b.kind == KIND_BOX) begin
          if (a.kind == KIND_BOX) begin
            prep_next.flag = in_b0 && in_b3;
          end else begin
            prep_next.mode = MODE_LT2;
            prep_next.flag = 1'b1;
          end
        end else if (a.kind == KIND_SPHERE) begin
          prep_next.mode = MODE_LT;
          prep_next.flag = br < av[3];
          prep_next.r    = rdiff;
        end else begin
          prep_next.flag = in_b0 && cs_ok;
        end
      end
      OP_NONE: begin
        prep_next.flag = 1'b0;
      end
      default: begin
        prep_next.flag = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep <= prep_next;
    end
  end

endmodule

@@ hdl/bvot_square.sv @@
// bounding volume overlap test: square stage, one squarer per distance term
// depends on bvot_pkg
`timescale 1ns / 1ps

module bvot_square import bvot_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  prep_t prep,
  output sqr_t  sqr
);

  sqr_t sqr_next;

  always_comb begin
    mag_t m;
    sqr_next.mode = prep.mode;
    sqr_next.flag = prep.flag;
    for (int i = 0; i < 3; i++) begin
      m = prep.p[i];
      sqr_next.p[i] = sq_t'(m) * sq_t'(m);
      m = prep.q[i];
      sqr_next.q[i] = sq_t'(m) * sq_t'(m);
    end
    sqr_next.r = sq_t'(prep.r) * sq_t'(prep.r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqr <= sqr_next;
    end
  end

endmodule

@@ hdl/bvot_decide.sv @@
// bounding volume overlap test: sums of squares, then the final compare
// depends on bvot_pkg
`timescale 1ns / 1ps

module bvot_decide import bvot_pkg::*; (
  input  logic      clk,
  input  logic      en_sum,
  input  logic      en_decide,
  input  sqr_t      sqr,
  output logic      hit
);

  sum_t  psum;
  sum_t  qsum;
  sum_t  rsq;
  mode_t mode;
  logic  flag;
  logic  hit_next;

  always_ff @(posedge clk) begin
    if (en_sum) begin
      psum <= sum_t'(sqr.p[0]) + sum_t'(sqr.p[1]) + sum_t'(sqr.p[2]);
      qsum <= sum_t'(sqr.q[0]) + sum_t'(sqr.q[1]) + sum_t'(sqr.q[2]);
      rsq  <= sum_t'(sqr.r);
      mode <= sqr.mode;
      flag <= sqr.flag;
    end
  end

  always_comb begin
    unique case (mode)
      MODE_FLAG: hit_next = flag;
      MODE_LE:   hit_next = flag && (psum <= rsq);
      MODE_LT:   hit_next = flag && (psum < rsq);
      MODE_LT2:  hit_next = (psum < rsq) && (qsum < rsq);
      default:   hit_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_decide) begin
      hit <= hit_next;
    end
  end

endmodule

@@ hdl/bounding_volume_overlap_test_unit.sv @@
// channel   direction  width     contents
// s_*       in         200 + 1   query item: opcode, region or point b; tuser b_kind
// m_*       out        8         result item: hit
// cfg_*     in         3 + 32    reference region a, one register per write
//
// five register stages: input, prep, square, sum, decide; one item per cycle while the output is not stalled
// an accepted item moves on through the prep, square, sum and decide registers to the output
// each stage refills as soon as the next one takes its item, so bubbles close up
// reset clears stage valids and the reference region; cfg is always ready
// top level of the block; depends on bvot_pkg, bvot_prep, bvot_square, bvot_decide
`timescale 1ns / 1ps

module bounding_volume_overlap_test_unit import bvot_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // opcode, b_coord_0 .. b_coord_5, zero pad
  input  logic [IN_TDW-1:0]  s_tdata,
  // b_kind
  input  logic               s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  // hit, zero pad
  output logic [OUT_TDW-1:0] m_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDXW-1:0]    cfg_index,
  input  logic [CW-1:0]      cfg_data
);

  region_t   areg;
  query_t    qreg;
  prep_t     prep;
  sqr_t      sqr;
  logic      hit;
  logic      v0, v1, v2, v3, v4;
  logic      rdy0, rdy1, rdy2, rdy3, rdy4;
  stage_en_t en;

  assign rdy4 = !v4 || m_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;

  assign en.prep   = rdy1;
  assign en.square = rdy2;
  assign en.sum    = rdy3;
  assign en.decide = rdy4;

  assign s_tready  = rdy0;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = v4;
  assign m_tdata   = {{(OUT_TDW-1){1'b0}}, hit};

  always_ff @(posedge clk) begin
    if (rst) begin
      areg <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_A_KIND) begin
        areg.kind <= kind_t'(cfg_data[0]);
      end
      for (int i = 0; i < NCOORD; i++) begin
        if (cfg_index == REG_A_COORD0 + IDXW'(i)) begin
          areg.coord[i] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy0) begin
        v0 <= s_tvalid;
      end
      if (rdy1) begin
        v1 <= v0;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      qreg.op     <= op_t'(s_tdata[OPW-1:0]);
      qreg.b.kind <= kind_t'(s_tuser);
      for (int i = 0; i < NCOORD; i++) begin
        qreg.b.coord[i] <= s_tdata[OPW + i*CW +: CW];
      end
    end
  end

  bvot_prep u_prep (
    .clk  (clk),
    .en   (en.prep),
    .a    (areg),
    .qin  (qreg),
    .prep (prep)
  );

  bvot_square u_square (
    .clk  (clk),
    .en   (en.square),
    .prep (prep),
    .sqr  (sqr)
  );

  bvot_decide u_decide (
    .clk       (clk),
    .en_sum    (en.sum),
    .en_decide (en.decide),
    .sqr       (sqr),
    .hit       (hit)
  );

endmodule

@@ hdl/bvot_checker.sv @@
// bounding volume overlap test: port checker and its bind to the top level
// depends on bvot_pkg and bounding_volume_overlap_test_unit
`timescale 1ns / 1ps

module bvot_checker import bvot_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [OUT_TDW-1:0] m_tdata,
  input logic               cfg_ready
);

  logic [2:0] cnt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> cnt != 3'd0)
    else $error("result item without an accepted item");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'd5)
    else $error("more items in flight than stages");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && cfg_ready)
    else $error("output valid or cfg not ready after reset");

endmodule

bind bounding_volume_overlap_test_unit bvot_checker u_bvot_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_ready (cfg_ready)
);

@@ verif/tb_top.sv @@
// testbench for bounding_volume_overlap_test_unit: random and directed queries
// against several reference regions, hit checked by an in-bench bit-exact predictor
// depends on bvot_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_top;
  import bvot_pkg::*;

  localparam int          U          = 65536;
  localparam int          MAXC       = 32'sh7fffffff;
  localparam int          MINC       = 32'sh80000000;
  localparam logic [2:0]  REG_UNUSED = 3'd7;

  typedef longint span_t [6];

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [IN_TDW-1:0]  s_tdata = '0;
  logic               s_tuser = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_TDW-1:0] m_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IDXW-1:0]    cfg_index = '0;
  logic [CW-1:0]      cfg_data = '0;

  // local copy of the reference region
  logic               a_kind_r = 1'b0;
  logic [CW-1:0]      a_coord_r [6] = '{default: '0};

  query_t query_backlog[$];
  bit     expected_hits[$];
  query_t in_flight;
  bit     tx_idle = 1'b0;
  bit     rx_stall = 1'b0;
  int     tx_gap = 0;
  int     rx_gap = 0;
  int     mismatches = 0;
  int     op_seen [4] = '{default: 0};
  int     hits_seen = 0;
  int     settings_run = 0;

  bounding_volume_overlap_test_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // exact geometry in wide integers
  function automatic logic [131:0] mag_sq(input longint d);
    longint unsigned m;
    logic [131:0]    w;
    m = (d < 0) ? -d : d;
    w = m;
    return w * w;
  endfunction

  function automatic logic [131:0] gap_sq(input span_t p, input span_t q, input int qo);
    logic [131:0] s;
    s = '0;
    for (int i = 0; i < 3; i++) s += mag_sq(p[i] - q[qo + i]);
    return s;
  endfunction

  function automatic bit in_box(input span_t bx, input span_t p, input int po);
    for (int i = 0; i < 3; i++)
      if (p[po + i] < bx[i] || p[po + i] > bx[i + 3]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit in_region(input bit sph, input span_t rg, input span_t p,
                                   input int po);
    if (!sph) return in_box(rg, p, po);
    return gap_sq(rg, p, po) < mag_sq(rg[3]);
  endfunction

  function automatic bit sphere_box_touch(input span_t sp, input span_t bx);
    logic [131:0] s;
    longint       t;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      t = (sp[i] < bx[i + 3]) ? sp[i] : bx[i + 3];
      if (t < bx[i]) t = bx[i];
      s += mag_sq(t - sp[i]);
    end
    return s < mag_sq(sp[3]);
  endfunction

  function automatic bit regions_meet(input bit ka, input span_t a, input bit kb,
                                      input span_t b);
    longint d, span;
    if (!ka && !kb) begin
      for (int i = 0; i < 3; i++) begin
        d = (a[i] + a[i + 3]) - (b[i] + b[i + 3]);
        span = (a[i + 3] - a[i]) + (b[i + 3] - b[i]);
        if (d < 0) d = -d;
        if (d > span) return 1'b0;
      end
      return 1'b1;
    end
    if (ka && kb) return !(mag_sq(a[3] + b[3]) < gap_sq(a, b, 0));
    if (ka) return sphere_box_touch(a, b);
    return sphere_box_touch(b, a);
  endfunction

  function automatic bit region_encloses(input bit ka, input span_t a, input bit kb,
                                         input span_t b);
    longint lo, hi;
    if (!kb) return in_region(ka, a, b, 0) && in_region(ka, a, b, 3);
    if (ka) return (b[3] < a[3]) && (gap_sq(a, b, 0) < mag_sq(a[3] - b[3]));
    if (!in_box(a, b, 0)) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      lo = b[i] - a[i];
      hi = a[i + 3] - b[i];
      if (lo < 0) lo = -lo;
      if (hi < 0) hi = -hi;
      if (lo < b[3] || hi < b[3]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit predict_hit(input query_t q);
    span_t a, b;
    bit    kb;
    kb = (q.b.kind == KIND_SPHERE);
    for (int i = 0; i < 6; i++) begin
      a[i] = $signed(a_coord_r[i]);
      b[i] = $signed(q.b.coord[i]);
    end
    case (q.op)
      OP_INTERSECT:  return regions_meet(a_kind_r, a, kb, b);
      OP_HAS_POINT:  return in_region(a_kind_r, a, b, 0);
      OP_HAS_REGION: return region_encloses(a_kind_r, a, kb, b);
      default:       return 1'b0;
    endcase
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // mostly near the origin, some full range and some extremes
  function automatic int rand_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 4))
          0: return MINC;
          1: return MAXC;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      1, 2: return $urandom;
      3, 4, 5: return ($urandom_range(0, 48) - 24) * U;
      default: return $urandom_range(0, 48 * U) - 24 * U;
    endcase
  endfunction

  function automatic int rand_extent();
    if ($urandom_range(0, 1)) return $urandom_range(0, 20) * U;
    return $urandom_range(0, 20 * U);
  endfunction

  function automatic int rand_radius();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 16 * U);
    if (r == 6) return $urandom_range(0, 16) * U;
    if (r == 7) return 0;
    if (r == 8) return -$urandom_range(1, 16 * U);
    return $urandom;
  endfunction

  function automatic query_t make_query(input op_t op, input kind_t k, input int c0,
                                        input int c1, input int c2, input int c3,
                                        input int c4, input int c5);
    query_t q;
    q.op = op;
    q.b.kind = k;
    q.b.coord[0] = c0;
    q.b.coord[1] = c1;
    q.b.coord[2] = c2;
    q.b.coord[3] = c3;
    q.b.coord[4] = c4;
    q.b.coord[5] = c5;
    return q;
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int     r;
    r = $urandom_range(0, 15);
    q.op = (r == 15) ? OP_NONE : op_t'(r % 3);
    q.b.kind = kind_t'($urandom_range(0, 1));
    for (int i = 0; i < 3; i++) q.b.coord[i] = rand_coord();
    for (int i = 3; i < 6; i++) q.b.coord[i] = $urandom;
    if (q.op != OP_HAS_POINT) begin
      if (q.b.kind == KIND_SPHERE) begin
        q.b.coord[3] = rand_radius();
      end else if ($urandom_range(0, 6) != 0) begin
        for (int i = 0; i < 3; i++) q.b.coord[i + 3] = q.b.coord[i] + rand_extent();
      end
    end
    return q;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_hits.push_back(predict_hit(in_flight));
        op_seen[in_flight.op]++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (query_backlog.size() > 0) begin
          in_flight = query_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= IN_TDW'({in_flight.b.coord, in_flight.op});
          s_tuser <= in_flight.b.kind;
          tx_gap = tx_idle ? gap_len() : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    bit want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_hits.size() == 0) begin
          $error("hit: result item with no query waiting, got %0d", m_tdata[0]);
          mismatches++;
        end else begin
          want = expected_hits.pop_front();
          if (m_tdata[0] !== want) begin
            $error("hit: expected %0d, got %0d", want, m_tdata[0]);
            mismatches++;
          end
          if (m_tdata[OUT_TDW-1:1] !== '0) begin
            $error("pad: expected 0, got %0h", m_tdata[OUT_TDW-1:1]);
            mismatches++;
          end
          if (want) hits_seen++;
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        rx_gap = rx_stall ? gap_len() : 0;
      end
    end
  end

  // sampled mid-cycle so the driver's updates at the edge are already visible
  task automatic settle();
    do @(negedge clk);
    while (query_backlog.size() != 0 || s_tvalid || expected_hits.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDXW-1:0] idx, input logic [CW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == REG_A_KIND) a_kind_r = data[0];
    else if (idx < REG_UNUSED) a_coord_r[idx - REG_A_COORD0] = data;
  endtask

  task automatic load_region(input kind_t k, input int c0, input int c1, input int c2,
                             input int c3, input int c4, input int c5);
    int c [6];
    c = '{c0, c1, c2, c3, c4, c5};
    write_reg(REG_A_KIND, ($urandom & ~32'd1) | 32'(k));
    for (int i = 0; i < 6; i++) write_reg(REG_A_COORD0 + IDXW'(i), c[i]);
    write_reg(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    settings_run++;
    tx_idle = $urandom_range(0, 3) != 0;
    rx_stall = $urandom_range(0, 3) != 0;
    @(negedge clk);
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) query_backlog.push_back(rand_query());
  endtask

  task automatic load_random_region();
    int c [6];
    kind_t k;
    k = kind_t'($urandom_range(0, 1));
    for (int i = 0; i < 3; i++) c[i] = rand_coord();
    for (int i = 3; i < 6; i++) c[i] = $urandom;
    if (k == KIND_SPHERE) c[3] = rand_radius();
    else if ($urandom_range(0, 5) != 0)
      for (int i = 0; i < 3; i++) c[i + 3] = c[i] + $urandom_range(1, 20 * U);
    load_region(k, c[0], c[1], c[2], c[3], c[4], c[5]);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset region: degenerate box at the origin
    settings_run++;
    tx_idle = 1'b1;
    rx_stall = 1'b1;
    queue_random(60);

    settle();
    load_region(KIND_BOX, -10 * U, -10 * U, -10 * U, 10 * U, 10 * U, 10 * U);
    // touching faces, just apart, sphere on the face, boundary points, enclosed regions, unused opcode
    query_backlog.push_back(make_query(OP_INTERSECT, KIND_BOX, 10 * U, -U, -U, 20 * U, U, U));
    query_backlog.push_back(make_query(OP_INTERSECT, KIND_BOX, 10 * U + 1, -U, -U,
                                       20 * U, U, U));
    query_backlog.push_back(make_query(OP_INTERSECT, KIND_SPHERE, 15 * U, 0, 0, 5 * U, 0, 0));
    query_backlog.push_back(make_query(OP_INTERSECT, KIND_SPHERE, 15 * U, 0, 0, 5 * U + 1,
                                       0, 0));
    query_backlog.push_back(make_query(OP_INTERSECT, KIND_BOX, MINC, MINC, MINC,
                                       MAXC, MAXC, MAXC));
    query_backlog.push_back(make_query(OP_HAS_POINT, KIND_BOX, 10 * U, 10 * U, 10 * U,
                                       MAXC, MINC, -1));
    query_backlog.push_back(make_query(OP_HAS_POINT, KIND_BOX, 10 * U + 1, 0, 0, 0, 0, 0));
    query_backlog.push_back(make_query(OP_HAS_POINT, KIND_SPHERE, MINC, MAXC, 0, 0, 0, 0));
    query_backlog.push_back(make_query(OP_HAS_REGION, KIND_BOX, -10 * U, -10 * U, -10 * U,
                                       10 * U, 10 * U, 10 * U));
    query_backlog.push_back(make_query(OP_HAS_REGION, KIND_SPHERE, 0, 0, 0, 10 * U, 0, 0));
    query_backlog.push_back(make_query(OP_HAS_REGION, KIND_SPHERE, 0, 0, 0, 10 * U + 1,
                                       0, 0));
    query_backlog.push_back(make_query(OP_NONE, KIND_BOX, -U, -U, -U, U, U, U));
    queue_random(100);

    settle();
    load_region(KIND_SPHERE, 0, 0, 0, 10 * U, $urandom, $urandom);
    query_backlog.push_back(make_query(OP_INTERSECT, KIND_SPHERE, 15 * U, 0, 0, 5 * U, 0, 0));
    query_backlog.push_back(make_query(OP_INTERSECT, KIND_SPHERE, 15 * U, 0, 0, -5 * U,
                                       0, 0));
    query_backlog.push_back(make_query(OP_INTERSECT, KIND_BOX, 10 * U, -U, -U, 20 * U, U, U));
    query_backlog.push_back(make_query(OP_INTERSECT, KIND_BOX, 9 * U, -U, -U, 20 * U, U, U));
    query_backlog.push_back(make_query(OP_HAS_POINT, KIND_BOX, 10 * U, 0, 0, 0, 0, 0));
    query_backlog.push_back(make_query(OP_HAS_POINT, KIND_SPHERE, 9 * U, 0, 0, 0, 0, 0));
    query_backlog.push_back(make_query(OP_HAS_POINT, KIND_BOX, MAXC, MAXC, MAXC, 0, 0, 0));
    query_backlog.push_back(make_query(OP_HAS_REGION, KIND_SPHERE, 0, 0, 0, 10 * U, 0, 0));
    query_backlog.push_back(make_query(OP_HAS_REGION, KIND_SPHERE, 5 * U, 0, 0, 5 * U, 0, 0));
    query_backlog.push_back(make_query(OP_HAS_REGION, KIND_SPHERE, 4 * U, 0, 0, 5 * U, 0, 0));
    query_backlog.push_back(make_query(OP_HAS_REGION, KIND_BOX, -5 * U, -5 * U, -5 * U,
                                       5 * U, 5 * U, 5 * U));
    query_backlog.push_back(make_query(OP_NONE, KIND_SPHERE, 0, 0, 0, 10 * U, 0, 0));
    queue_random(100);

    settle();
    load_region(KIND_BOX, MINC, MINC, MINC, MAXC, MAXC, MAXC);
    queue_random(80);

    settle();
    load_region(KIND_SPHERE, MINC, MAXC, 0, MAXC, MAXC, MINC);
    queue_random(80);

    // negative radius
    settle();
    load_region(KIND_SPHERE, U, -U, 3 * U, MINC, 0, 0);
    queue_random(60);

    // inverted box
    settle();
    load_region(KIND_BOX, 10 * U, 10 * U, 10 * U, -10 * U, -10 * U, -10 * U);
    queue_random(60);

    for (int p = 0; p < 8; p++) begin
      settle();
      load_random_region();
      if (p == 3) begin
        tx_idle = 1'b0;
        rx_stall = 1'b0;
      end
      queue_random(80);
    end

    settle();
    repeat (10) @(posedge clk);
    $display("checked %0d queries: %0d intersect, %0d point, %0d region, %0d unused opcode",
             op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
             op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("%0d reference region settings, %0d hits expected", settings_run, hits_seen);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout waiting for result items");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
hdl/bvot_pkg.sv
hdl/bvot_prep.sv
hdl/bvot_square.sv
hdl/bvot_decide.sv
hdl/bounding_volume_overlap_test_unit.sv
hdl/bvot_checker.sv
verif/tb_top.sv
